/* sv/swia_pkg.sv */
// Shared types and constants for the indexed-access stack.
`default_nettype none
package swia_pkg;

	// field widths
	localparam int DATA_W = 32;
	localparam int CMD_W = 2;
	localparam int POS_W = 8;
	localparam int STAT_W = 2;
	localparam int CNT_W = 8;

	// default number of cells
	localparam int DEPTH_DEF = 128;

	// command codes
	localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
	localparam logic [CMD_W-1:0] CMD_POP = 2'd1;
	localparam logic [CMD_W-1:0] CMD_PEEK = 2'd2;
	localparam logic [CMD_W-1:0] CMD_CHANGE = 2'd3;

	// status codes
	localparam logic [STAT_W-1:0] STAT_OK = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;
	localparam logic [STAT_W-1:0] STAT_BADPOS = 2'd3;

	// controller states
	typedef enum logic {
		ST_IDLE,
		ST_SHIFT
	} state_t;

	// per-cycle control broadcast to every cell
	typedef struct packed {
		logic push;       // shift entries down, top takes the new word
		logic pop;        // shift entries up
		logic change;     // the cell at the given position takes the new word
		logic load_tap;   // snapshot entries into the read-out chain
		logic shift_tap;  // move the read-out chain one cell toward the top
	} cell_ctl_t;

endpackage
`default_nettype wire

/* sv/stack_with_indexed_access_unit.sv */
// Top level of the indexed-access stack: a chain of cells and its controller.
//
// Usage: drive command, value and position and raise start; the word is taken
// at the rising edge where start is high and busy is low. Each command returns
// exactly one result word on data, status and count, marked by done for one
// cycle; the receiver must take it in that cycle.
// Push, pop, change, peek of the top and every error return their result in the
// cycle after acceptance, and busy stays low, so such commands can be issued
// every cycle. A peek at position p > 1 snapshots the cells into a read-out
// chain that moves one cell toward the top per cycle; busy is high during the
// walk, and the result is returned once the word reaches the top of the chain.
// Throughput is one command per cycle while busy is low; none is taken in a walk.
// Reset (arst_n low) empties the stack and clears done; cell contents are not
// cleared and are read only after being written by a push.
// count reports the low 8 bits of the element count after the command.
`default_nettype none
module stack_with_indexed_access_unit #(
	parameter int DEPTH = swia_pkg::DEPTH_DEF
) (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  wire                                    start,
	output logic                                   busy,
	input  wire         [swia_pkg::CMD_W-1:0]      command,
	input  wire  signed [swia_pkg::DATA_W-1:0]     value,
	input  wire         [swia_pkg::POS_W-1:0]      position,
	output logic                                   done,
	output logic signed [swia_pkg::DATA_W-1:0]     data,
	output logic        [swia_pkg::STAT_W-1:0]     status,
	output logic        [swia_pkg::CNT_W-1:0]      count
);

	localparam int DW = swia_pkg::DATA_W;

	swia_pkg::cell_ctl_t ctl;
	logic [DW-1:0]       entry_w [DEPTH];
	logic [DW-1:0]       tap_w [DEPTH];
	logic [DW-1:0]       data_w;

	// row of cells, index 0 is the top of the stack
	for (genvar k = 0; k < DEPTH; k++) begin : g_cell
		logic [DW-1:0] above;
		logic [DW-1:0] below;
		logic [DW-1:0] tap_in;

		if (k == 0) begin : g_top
			assign above = value;
		end else begin : g_mid
			assign above = entry_w[k-1];
		end

		if (k == DEPTH - 1) begin : g_bot
			assign below = '0;
			assign tap_in = '0;
		end else begin : g_up
			assign below = entry_w[k+1];
			assign tap_in = tap_w[k+1];
		end

		swia_cell #(
			.IDX(k)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.position   (position),
			.value      (value),
			.entry_above(above),
			.entry_below(below),
			.tap_below  (tap_in),
			.entry      (entry_w[k]),
			.tap        (tap_w[k])
		);
	end

	// command decode and result registers
	swia_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.command  (command),
		.value    (value),
		.position (position),
		.top_entry(entry_w[0]),
		.tap_next (tap_w[1]),
		.ctl      (ctl),
		.busy     (busy),
		.done     (done),
		.data     (data_w),
		.status   (status),
		.count    (count)
	);

	assign data = data_w;

endmodule
`default_nettype wire

/* sv/swia_cell.sv */
// One stack cell: holds the entry at a fixed depth and one read-out tap.
`default_nettype none
module swia_cell #(
	parameter int IDX = 0
) (
	input  wire                              clk,
	input  wire  swia_pkg::cell_ctl_t        ctl,
	input  wire  [swia_pkg::POS_W-1:0]       position,
	input  wire  [swia_pkg::DATA_W-1:0]      value,
	input  wire  [swia_pkg::DATA_W-1:0]      entry_above,
	input  wire  [swia_pkg::DATA_W-1:0]      entry_below,
	input  wire  [swia_pkg::DATA_W-1:0]      tap_below,
	output logic [swia_pkg::DATA_W-1:0]      entry,
	output logic [swia_pkg::DATA_W-1:0]      tap
);

	// depth of this cell counted from the top, 1 = top
	localparam int unsigned SEL = IDX + 1;

	logic [swia_pkg::DATA_W-1:0] entry_q;
	logic [swia_pkg::DATA_W-1:0] tap_q;
	logic                        hit;

	assign hit = (32'(position) == SEL);

	// entry storage: shift with the stack or take an in-place write
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			entry_q <= entry_above;
		end else if (ctl.pop) begin
			entry_q <= entry_below;
		end else if (ctl.change && hit) begin
			entry_q <= value;
		end
	end

	// read-out chain: snapshot, then walk toward the top
	always_ff @(posedge clk) begin
		if (ctl.load_tap) begin
			tap_q <= entry_q;
		end else if (ctl.shift_tap) begin
			tap_q <= tap_below;
		end
	end

	assign entry = entry_q;
	assign tap = tap_q;

endmodule
`default_nettype wire

/* sv/swia_ctrl.sv */
// Controller: fill count, command decode, peek walk and result registers.
`default_nettype none
module swia_ctrl #(
	parameter int DEPTH = swia_pkg::DEPTH_DEF
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  start,
	input  wire  [swia_pkg::CMD_W-1:0]           command,
	input  wire  [swia_pkg::DATA_W-1:0]          value,
	input  wire  [swia_pkg::POS_W-1:0]           position,
	input  wire  [swia_pkg::DATA_W-1:0]          top_entry,
	input  wire  [swia_pkg::DATA_W-1:0]          tap_next,
	output swia_pkg::cell_ctl_t                  ctl,
	output logic                                 busy,
	output logic                                 done,
	output logic [swia_pkg::DATA_W-1:0]          data,
	output logic [swia_pkg::STAT_W-1:0]          status,
	output logic [swia_pkg::CNT_W-1:0]           count
);

	localparam int FW = $clog2(DEPTH + 1);
	localparam int CW = swia_pkg::CNT_W;
	localparam int PW = swia_pkg::POS_W;
	localparam logic [FW-1:0] FULL_CNT = FW'(DEPTH);

	swia_pkg::state_t state_q, state_d;

	logic [FW-1:0]                   fill_q, fill_d;
	logic [PW-1:0]                   walk_q, walk_d;
	logic                            accept;
	logic                            bad_pos;
	logic                            res_vld;
	logic [swia_pkg::DATA_W-1:0]     res_data;
	logic [swia_pkg::STAT_W-1:0]     res_stat;

	logic                            done_q;
	logic [swia_pkg::DATA_W-1:0]     data_q;
	logic [swia_pkg::STAT_W-1:0]     status_q;
	logic [CW-1:0]                   count_q;

	assign busy = (state_q == swia_pkg::ST_SHIFT);
	assign accept = start && !busy;
	assign bad_pos = (position == '0) || (32'(position) > 32'(fill_q));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			swia_pkg::ST_IDLE: begin
				if (accept && (command == swia_pkg::CMD_PEEK) && !bad_pos &&
				    (position != PW'(1))) begin
					state_d = swia_pkg::ST_SHIFT;
				end
			end
			swia_pkg::ST_SHIFT: begin
				if (walk_q == PW'(1)) begin
					state_d = swia_pkg::ST_IDLE;
				end
			end
			default: state_d = swia_pkg::ST_IDLE;
		endcase
	end

	// outputs: cell controls, fill and walk updates, result word
	always_comb begin
		ctl = '0;
		fill_d = fill_q;
		walk_d = walk_q;
		res_vld = 1'b0;
		res_data = '0;
		res_stat = swia_pkg::STAT_OK;
		case (state_q)
			swia_pkg::ST_IDLE: begin
				if (accept) begin
					res_vld = 1'b1;
					case (command)
						swia_pkg::CMD_PUSH: begin
							if (fill_q == FULL_CNT) begin
								res_stat = swia_pkg::STAT_FULL;
							end else begin
								ctl.push = 1'b1;
								fill_d = fill_q + FW'(1);
								res_data = value;
							end
						end
						swia_pkg::CMD_POP: begin
							if (fill_q == '0) begin
								res_stat = swia_pkg::STAT_EMPTY;
							end else begin
								ctl.pop = 1'b1;
								fill_d = fill_q - FW'(1);
								res_data = top_entry;
							end
						end
						swia_pkg::CMD_CHANGE: begin
							if (bad_pos) begin
								res_stat = swia_pkg::STAT_BADPOS;
							end else begin
								ctl.change = 1'b1;
								res_data = value;
							end
						end
						default: begin
							// peek
							if (bad_pos) begin
								res_stat = swia_pkg::STAT_BADPOS;
							end else if (position == PW'(1)) begin
								res_data = top_entry;
							end else begin
								ctl.load_tap = 1'b1;
								walk_d = position - PW'(1);
								res_vld = 1'b0;
							end
						end
					endcase
				end
			end
			swia_pkg::ST_SHIFT: begin
				if (walk_q == PW'(1)) begin
					res_vld = 1'b1;
					res_data = tap_next;
				end else begin
					ctl.shift_tap = 1'b1;
					walk_d = walk_q - PW'(1);
				end
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= swia_pkg::ST_IDLE;
			fill_q <= '0;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			fill_q <= fill_d;
			done_q <= res_vld;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		walk_q <= walk_d;
		if (res_vld) begin
			data_q <= res_data;
			status_q <= res_stat;
			count_q <= CW'(fill_d);
		end
	end

	assign done = done_q;
	assign data = data_q;
	assign status = status_q;
	assign count = count_q;

endmodule
`default_nettype wire

/* sv/swia_checker.sv */
// Port-level checker for the indexed-access stack, bound to the top level.
`default_nettype none
module swia_checker (
	input wire                                clk,
	input wire                                arst_n,
	input wire                                start,
	input wire                                busy,
	input wire [swia_pkg::CMD_W-1:0]          command,
	input wire [swia_pkg::DATA_W-1:0]         value,
	input wire [swia_pkg::POS_W-1:0]          position,
	input wire                                done,
	input wire [swia_pkg::DATA_W-1:0]         data,
	input wire [swia_pkg::STAT_W-1:0]         status,
	input wire [swia_pkg::CNT_W-1:0]          count
);

	// a result word never shows while a peek walk is running
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while busy");

	// every command other than peek answers in the next cycle
	a_fast_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (command != swia_pkg::CMD_PEEK)) |=> done)
		else $error("missing result for fast command");

	// a running walk ends only with its result
	a_walk_ends: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> (busy || done))
		else $error("walk ended without result");

	// error results carry zero data
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status != swia_pkg::STAT_OK)) |-> (data == '0))
		else $error("nonzero data on error");

	// an empty pop reports an empty stack
	a_empty_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == swia_pkg::STAT_EMPTY)) |-> (count == '0))
		else $error("empty status with nonzero count");

endmodule

bind stack_with_indexed_access_unit swia_checker u_swia_checker (.*);
`default_nettype wire
